FILE: hdl/crt_pkg.sv
// Package for the CAN register request tracker.
// Holds command, result and register codes, frame constants and shared types.
// No dependencies.
package crt_pkg;

    localparam int DEF_NUM_SLOTS = 8;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FRAME = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [2:0] KIND_TX        = 3'd0;
    localparam logic [2:0] KIND_COMPLETE  = 3'd1;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd2;
    localparam logic [2:0] KIND_NO_SLOT   = 3'd3;
    localparam logic [2:0] KIND_BAD_LEN   = 3'd4;
    localparam logic [2:0] KIND_UNMATCHED = 3'd5;
    localparam logic [2:0] KIND_NO_ACK    = 3'd6;

    localparam logic [1:0] CFG_NODE_ADDR   = 2'd0;
    localparam logic [1:0] CFG_READ_TMO    = 2'd1;
    localparam logic [1:0] CFG_WRITE_TMO   = 2'd2;

    localparam logic [15:0] BCAST_ADDR      = 16'hFFFF;
    localparam logic [7:0]  RST_TIMEOUT     = 8'd10;
    localparam logic [3:0]  MAX_WRITE_LEN   = 4'd8;
    localparam int          ACK_BIT         = 27;

    typedef struct packed {
        logic        valid;
        logic        bcast;
        logic [15:0] dev;
        logic [10:0] regnum;
        logic [7:0]  cd;
    } t_slot_entry;

    typedef struct packed {
        logic       hit;
        logic [7:0] cd_next;
    } t_scan_res;

endpackage

FILE: hdl/crt_intf.sv
// Valid/ready channel interfaces for request beats and result beats.
// Depends on nothing but the field widths of the tracker.
interface crt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] dev_addr;
    logic [10:0] reg_num;
    logic [7:0]  timeout_ticks;
    logic [31:0] request_tag;
    logic [63:0] payload;
    logic [3:0]  payload_len;
    logic [28:0] frame_id;
    logic        frame_rtr;

    modport source (output valid, cmd, dev_addr, reg_num, timeout_ticks, request_tag,
                    payload, payload_len, frame_id, frame_rtr, input ready);
    modport sink (input valid, cmd, dev_addr, reg_num, timeout_ticks, request_tag,
                  payload, payload_len, frame_id, frame_rtr, output ready);
endinterface

interface crt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [28:0] out_identifier;
    logic        out_rtr;
    logic [3:0]  out_len;
    logic [63:0] out_data;
    logic [31:0] out_tag;
    logic [2:0]  out_slot;
    logic        last_result;

    modport source (output valid, result_kind, out_identifier, out_rtr, out_len,
                    out_data, out_tag, out_slot, last_result, input ready);
    modport sink (input valid, result_kind, out_identifier, out_rtr, out_len,
                  out_data, out_tag, out_slot, last_result, output ready);
endinterface

FILE: hdl/can_register_request_tracker_top.sv
// CAN register request tracker: slot table, scan sequencer and result register.
// Depends on crt_pkg, crt_intf (crt_req_if, crt_rsp_if) and crt_scan_unit.
// Scan: an item walks the slots one per cycle while no result beat waits on o_rsp.ready, and
// each result is registered in the cycle that decides it: for an issue or frame, the first
// hit or the last slot; for a tick, every expiring slot.
// A new item is taken only when idle, after the single shared scan unit finishes the last one.
// Reset clears all slots and sets node address 0 and both default timeouts to 10.
module can_register_request_tracker_top #(
    parameter int NUM_SLOTS = crt_pkg::DEF_NUM_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    crt_req_if.sink     i_req,
    crt_rsp_if.source   o_rsp
);
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic [15:0] r_node_addr;
    logic [7:0]  r_def_rd;
    logic [7:0]  r_def_wr;

    logic [1:0]  r_cmd;
    logic [15:0] r_dev;
    logic [10:0] r_regnum;
    logic [7:0]  r_tmo;
    logic [31:0] r_tag;
    logic [63:0] r_pay;
    logic [3:0]  r_len;
    logic [28:0] r_fid;
    logic        r_frtr;

    logic [NUM_SLOTS-1:0] r_valid;
    logic [7:0]           r_cd     [NUM_SLOTS];
    logic                 r_bcast  [NUM_SLOTS];
    logic [15:0]          r_dev_a  [NUM_SLOTS];
    logic [10:0]          r_reg_a  [NUM_SLOTS];
    logic [31:0]          r_tag_a  [NUM_SLOTS];

    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [28:0] r_ident;
    logic        r_rtr;
    logic [3:0]  r_olen;
    logic [63:0] r_data;
    logic [31:0] r_otag;
    logic [2:0]  r_slot;
    logic        r_last;

    crt_pkg::t_slot_entry entry;
    crt_pkg::t_scan_res   res;

    logic        is_issue;
    logic        is_tick;
    logic        at_end;
    logic        can_load;
    logic        need_out;
    logic        proceed;
    logic        finish;
    logic        later;
    logic        bcast_req;
    logic [31:0] idx_wide;
    logic [63:0] wr_data;
    logic [28:0] req_ident;

    logic [2:0]  n_kind;
    logic [28:0] n_ident;
    logic        n_rtr;
    logic [3:0]  n_olen;
    logic [63:0] n_data;
    logic [31:0] n_otag;
    logic [2:0]  n_slot;
    logic        n_last;

    assign entry.valid  = r_valid[r_idx];
    assign entry.bcast  = r_bcast[r_idx];
    assign entry.dev    = r_dev_a[r_idx];
    assign entry.regnum = r_reg_a[r_idx];
    assign entry.cd     = r_cd[r_idx];

    crt_scan_unit u_scan (
        .i_cmd    (r_cmd),
        .i_len    (r_len),
        .i_tmo    (r_tmo),
        .i_fid    (r_fid),
        .i_def_rd (r_def_rd),
        .i_def_wr (r_def_wr),
        .i_entry  (entry),
        .o_res    (res)
    );

    assign is_issue  = (r_cmd == crt_pkg::CMD_READ) || (r_cmd == crt_pkg::CMD_WRITE);
    assign is_tick   = (r_cmd == crt_pkg::CMD_TICK);
    assign at_end    = (r_idx == LAST_IDX);
    assign can_load  = !r_out_valid || o_rsp.ready;
    assign need_out  = is_tick ? res.hit : (res.hit || at_end);
    assign proceed   = (r_state == S_SCAN) && (!need_out || can_load);
    assign finish    = is_tick ? at_end : (res.hit || at_end);
    assign idx_wide  = 32'(r_idx);
    assign bcast_req = (r_dev == crt_pkg::BCAST_ADDR);
    assign req_ident = {2'b00, (bcast_req ? crt_pkg::BCAST_ADDR : r_node_addr), r_regnum};

    always_comb begin
        later = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if ((j > int'(idx_wide)) && r_valid[j] && (r_cd[j] <= 8'd1)) begin
                later = 1'b1;
            end
        end
    end

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            wr_data[b*8 +: 8] = (4'(b) < r_len) ? r_pay[b*8 +: 8] : 8'd0;
        end
    end

    always_comb begin
        n_kind  = crt_pkg::KIND_TX;
        n_ident = '0;
        n_rtr   = 1'b0;
        n_olen  = '0;
        n_data  = '0;
        n_otag  = '0;
        n_slot  = '0;
        n_last  = 1'b1;
        priority if (is_tick) begin
            n_kind = crt_pkg::KIND_TIMEOUT;
            n_otag = r_tag_a[r_idx];
            n_slot = idx_wide[2:0];
            n_last = !later;
        end else if (is_issue) begin
            if (res.hit) begin
                n_kind  = crt_pkg::KIND_TX;
                n_ident = req_ident;
                n_rtr   = (r_cmd == crt_pkg::CMD_READ);
                n_olen  = (r_cmd == crt_pkg::CMD_READ) ? 4'd0 : r_len;
                n_data  = (r_cmd == crt_pkg::CMD_READ) ? 64'd0 : wr_data;
                n_otag  = r_tag;
                n_slot  = idx_wide[2:0];
            end else if ((r_cmd == crt_pkg::CMD_WRITE) && (r_len > crt_pkg::MAX_WRITE_LEN)) begin
                n_kind = crt_pkg::KIND_BAD_LEN;
            end else begin
                n_kind = crt_pkg::KIND_NO_SLOT;
            end
        end else begin
            n_ident = r_fid;
            n_rtr   = r_frtr;
            n_olen  = r_len;
            n_data  = r_pay;
            if (res.hit) begin
                n_kind = r_fid[crt_pkg::ACK_BIT] ? crt_pkg::KIND_COMPLETE
                                                 : crt_pkg::KIND_NO_ACK;
                n_otag = r_tag_a[r_idx];
                n_slot = idx_wide[2:0];
            end else begin
                n_kind = crt_pkg::KIND_UNMATCHED;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            default: begin
                if (proceed) begin
                    if (finish) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_node_addr <= '0;
            r_def_rd    <= crt_pkg::RST_TIMEOUT;
            r_def_wr    <= crt_pkg::RST_TIMEOUT;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_cd[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    crt_pkg::CFG_NODE_ADDR: r_node_addr <= i_cfg_data;
                    crt_pkg::CFG_READ_TMO:  r_def_rd    <= i_cfg_data[7:0];
                    crt_pkg::CFG_WRITE_TMO: r_def_wr    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (proceed && need_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (proceed) begin
                priority if (is_tick) begin
                    if (entry.valid) begin
                        r_cd[r_idx] <= res.cd_next;
                        if (res.hit) begin
                            r_valid[r_idx] <= 1'b0;
                        end
                    end
                end else if (is_issue) begin
                    if (res.hit) begin
                        r_valid[r_idx] <= 1'b1;
                        r_cd[r_idx]    <= res.cd_next;
                    end
                end else begin
                    if (res.hit && r_fid[crt_pkg::ACK_BIT]) begin
                        r_valid[r_idx] <= 1'b0;
                        r_cd[r_idx]    <= res.cd_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_req.valid) begin
            r_cmd    <= i_req.cmd;
            r_dev    <= i_req.dev_addr;
            r_regnum <= i_req.reg_num;
            r_tmo    <= i_req.timeout_ticks;
            r_tag    <= i_req.request_tag;
            r_pay    <= i_req.payload;
            r_len    <= i_req.payload_len;
            r_fid    <= i_req.frame_id;
            r_frtr   <= i_req.frame_rtr;
        end
        if (proceed && is_issue && res.hit) begin
            r_bcast[r_idx] <= bcast_req;
            r_dev_a[r_idx] <= r_dev;
            r_reg_a[r_idx] <= r_regnum;
            r_tag_a[r_idx] <= r_tag;
        end
        if (proceed && need_out) begin
            r_kind  <= n_kind;
            r_ident <= n_ident;
            r_rtr   <= n_rtr;
            r_olen  <= n_olen;
            r_data  <= n_data;
            r_otag  <= n_otag;
            r_slot  <= n_slot;
            r_last  <= n_last;
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_kind    = r_kind;
    assign o_rsp.out_identifier = r_ident;
    assign o_rsp.out_rtr        = r_rtr;
    assign o_rsp.out_len        = r_olen;
    assign o_rsp.out_data       = r_data;
    assign o_rsp.out_tag        = r_otag;
    assign o_rsp.out_slot       = r_slot;
    assign o_rsp.last_result    = r_last;

endmodule

FILE: hdl/crt_scan_unit.sv
// Shared per-slot compare and countdown unit, applied to one slot per cycle while the scan is not stalled.
// Depends on crt_pkg.
module crt_scan_unit (
    input  logic [1:0]          i_cmd,
    input  logic [3:0]          i_len,
    input  logic [7:0]          i_tmo,
    input  logic [28:0]         i_fid,
    input  logic [7:0]          i_def_rd,
    input  logic [7:0]          i_def_wr,
    input  crt_pkg::t_slot_entry i_entry,
    output crt_pkg::t_scan_res   o_res
);
    logic bad_len;
    logic expire;

    assign bad_len = (i_cmd == crt_pkg::CMD_WRITE) && (i_len > crt_pkg::MAX_WRITE_LEN);
    assign expire  = i_entry.cd <= 8'd1;

    always_comb begin
        o_res = '0;
        unique case (i_cmd)
            crt_pkg::CMD_READ, crt_pkg::CMD_WRITE: begin
                o_res.hit = !i_entry.valid && !bad_len;
                if (i_tmo != 8'd0) begin
                    o_res.cd_next = i_tmo;
                end else if (i_cmd == crt_pkg::CMD_READ) begin
                    o_res.cd_next = i_def_rd;
                end else begin
                    o_res.cd_next = i_def_wr;
                end
            end
            crt_pkg::CMD_FRAME: begin
                o_res.hit = i_entry.valid && (i_entry.regnum == i_fid[10:0]) &&
                            (i_entry.bcast || (i_entry.dev == i_fid[26:11]));
                o_res.cd_next = 8'd0;
            end
            default: begin
                o_res.hit     = i_entry.valid && expire;
                o_res.cd_next = expire ? 8'd0 : i_entry.cd - 8'd1;
            end
        endcase
    end
endmodule
